// File: hdl/nzda_pkg.sv
// ---------------------------------------------------------------------------
// nzda_pkg
// Shared constants for the ZDA sentence parser: phase codes, sequencer codes,
// character codes, word sizes, the fraction limit and the hex digit decode.
// ---------------------------------------------------------------------------
package nzda_pkg;

    // fixed word sizes
    localparam int ID_CHARS    = 2;
    localparam int CHECK_CHARS = 2;

    // saturation limit of the fraction
    localparam logic [29:0] FRAC_MAX = 30'd999999999;

    // parse phases
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_TALKER  = 3'd1;
    localparam logic [2:0] PH_MESSAGE = 3'd2;
    localparam logic [2:0] PH_FIELD   = 3'd3;
    localparam logic [2:0] PH_CHECK   = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;

    // sequencer states
    localparam logic [1:0] SQ_WAIT = 2'd0;
    localparam logic [1:0] SQ_DEC  = 2'd1;
    localparam logic [1:0] SQ_PUB  = 2'd2;

    // character codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_Z      = 8'h5A;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_A      = 8'h41;

    // hex digit decode: bit 4 flags a valid digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

// File: hdl/nmea_zda_sentence_parser.sv
// ---------------------------------------------------------------------------
// nmea_zda_sentence_parser
// Character-serial parser for GPZDA sentences with checksum check and
// decoded time registers.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, ch) takes one received character per
//   item. Output channel (out_valid/out_ready) returns one item per
//   character: sentence_done and the current decoded time fields.
//   Most characters go from the wait state to the publish state, which
//   loads the output register. The ',' or '*' that ends data fields 0
//   to 3, if long enough, first starts a decode loop that walks the
//   stored field one character per cycle through a shared multiply-by-ten
//   digit unit over the field length (at least 6) for the time field; 2, 2
//   or 4 for day, month, year. One item is in work at a time; in_ready is
//   high only in the wait state, so no character is taken until the last
//   result is loaded. If the receiver stalls, the result holds in the
//   output register and the next character may be taken and processed
//   meanwhile; its result waits until the slot frees.
//   Reset clears the parse state, the checksum and all time fields to zero
//   and leaves the block idle, waiting for '$'.
// ---------------------------------------------------------------------------
module nmea_zda_sentence_parser
    import nzda_pkg::*;
#(
    parameter int MSG_CHARS   = 3,
    parameter int FIELD_CHARS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        sentence_done,
    output logic [6:0]  hour,
    output logic [6:0]  minute,
    output logic [6:0]  second,
    output logic [29:0] fraction,
    output logic [6:0]  day,
    output logic [6:0]  month,
    output logic [13:0] year
);

    localparam int CNT_W  = $clog2(FIELD_CHARS + 1);
    localparam int IDX_W  = $clog2(FIELD_CHARS);
    localparam int MIDX_W = $clog2(MSG_CHARS);

    // control state
    logic [1:0]       seq_reg, seq_next;
    logic [2:0]       phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic             zseen_reg, zseen_next;
    logic [7:0]       xor_reg, xor_next;
    logic [2:0]       fnum_reg, fnum_next;
    logic             ok_reg, ok_next;
    logic             star_reg, star_next;
    logic [1:0]       dfield_reg, dfield_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] endp_reg, endp_next;
    logic [29:0]      acc_reg, acc_next;
    logic             out_valid_reg, out_valid_next;

    // time registers
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  minute_reg, minute_next;
    logic [6:0]  second_reg, second_next;
    logic [29:0] fraction_reg, fraction_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  month_reg, month_next;
    logic [13:0] year_reg, year_next;

    // word stores
    logic [7:0] talker_reg [ID_CHARS];
    logic [7:0] msg_reg    [MSG_CHARS];
    logic [7:0] field_reg  [FIELD_CHARS];
    logic [7:0] chk_reg    [CHECK_CHARS];
    logic       talk_we, msg_we, fld_we, chk_we;

    // output register
    logic        done_out_reg;
    logic [6:0]  hour_out_reg, minute_out_reg, second_out_reg;
    logic [29:0] fraction_out_reg;
    logic [6:0]  day_out_reg, month_out_reg;
    logic [13:0] year_out_reg;
    logic        load_out;

    // helpers
    logic             accept;
    logic             is_delim;
    logic             clr_word, do_fail, zero_time;
    logic [4:0]       hx0, hx1;
    logic [7:0]       chk_val;
    logic [7:0]       fc;
    logic             fc_digit, dot_pos, last_pos;
    logic [33:0]      prod;
    logic [29:0]      acc_sat;
    logic [CNT_W-1:0] need_len;

    assign in_ready = (seq_reg == SQ_WAIT);
    assign accept   = in_valid && in_ready;
    assign is_delim = (ch == CH_COMMA) || (ch == CH_STAR) || (ch == CH_CR) || (ch == CH_LF);

    // checksum text value
    assign hx0 = hex_digit(chk_reg[0]);
    assign hx1 = hex_digit(chk_reg[1]);
    always_comb
    begin
        chk_val = 8'd0;
        if (cnt_reg >= CNT_W'(1) && hx0[4])
        begin
            chk_val = {4'd0, hx0[3:0]};
            if (cnt_reg >= CNT_W'(2) && hx1[4])
            begin
                chk_val = {hx0[3:0], hx1[3:0]};
            end
        end
    end

    // shared digit unit: acc * 10 + digit, saturated
    assign fc       = field_reg[pos_reg];
    assign fc_digit = (fc >= CH_ZERO) && (fc <= CH_NINE);
    assign prod     = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                      + {30'd0, 4'(fc - CH_ZERO)};
    assign acc_sat  = (prod > {4'd0, FRAC_MAX}) ? FRAC_MAX : prod[29:0];
    assign dot_pos  = (dfield_reg == 2'd0) && (pos_reg == IDX_W'(6));
    assign last_pos = (CNT_W'(pos_reg) + CNT_W'(1)) == endp_reg;

    // minimum length of each decoded field
    always_comb
    begin
        case (fnum_reg)
            3'd0:    need_len = CNT_W'(6);
            3'd3:    need_len = CNT_W'(4);
            default: need_len = CNT_W'(2);
        endcase
    end

    // parse and decode sequencer
    always_comb
    begin
        seq_next       = seq_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        zseen_next     = zseen_reg;
        xor_next       = xor_reg;
        fnum_next      = fnum_reg;
        ok_next        = ok_reg;
        star_next      = star_reg;
        dfield_next    = dfield_reg;
        pos_next       = pos_reg;
        endp_next      = endp_reg;
        acc_next       = acc_reg;
        hour_next      = hour_reg;
        minute_next    = minute_reg;
        second_next    = second_reg;
        fraction_next  = fraction_reg;
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        talk_we        = 1'b0;
        msg_we         = 1'b0;
        fld_we         = 1'b0;
        chk_we         = 1'b0;
        clr_word       = 1'b0;
        do_fail        = 1'b0;
        zero_time      = 1'b0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        case (seq_reg)
            SQ_WAIT:
            begin
                if (accept)
                begin
                    seq_next = SQ_PUB;
                    case (phase_reg)
                        PH_IDLE:
                        begin
                            if (ch == CH_DOLLAR)
                            begin
                                clr_word   = 1'b1;
                                phase_next = PH_TALKER;
                            end
                        end
                        PH_TALKER:
                        begin
                            if (ch != CH_STAR)
                            begin
                                xor_next = xor_reg ^ ch;
                            end
                            if (cnt_reg < CNT_W'(ID_CHARS) && !is_delim)
                            begin
                                talk_we  = 1'b1;
                                cnt_next = cnt_reg + CNT_W'(1);
                                if (cnt_reg == CNT_W'(1))
                                begin
                                    if (talker_reg[0] == CH_G && ch == CH_P)
                                    begin
                                        clr_word   = 1'b1;
                                        phase_next = PH_MESSAGE;
                                    end
                                    else
                                    begin
                                        do_fail = 1'b1;
                                    end
                                end
                            end
                        end
                        PH_MESSAGE:
                        begin
                            if (ch != CH_STAR)
                            begin
                                xor_next = xor_reg ^ ch;
                            end
                            if (cnt_reg < CNT_W'(MSG_CHARS) && !is_delim)
                            begin
                                msg_we   = 1'b1;
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                            if (ch == CH_COMMA)
                            begin
                                if (cnt_reg == CNT_W'(3) && msg_reg[0] == CH_Z &&
                                    msg_reg[1] == CH_D && msg_reg[2] == CH_A)
                                begin
                                    clr_word   = 1'b1;
                                    phase_next = PH_FIELD;
                                end
                                else
                                begin
                                    do_fail = 1'b1;
                                end
                            end
                        end
                        PH_FIELD:
                        begin
                            if (ch != CH_STAR)
                            begin
                                xor_next = xor_reg ^ ch;
                            end
                            if (cnt_reg < CNT_W'(FIELD_CHARS) && !is_delim)
                            begin
                                fld_we   = 1'b1;
                                cnt_next = cnt_reg + CNT_W'(1);
                                if (!zseen_reg)
                                begin
                                    if (ch == 8'd0)
                                    begin
                                        zseen_next = 1'b1;
                                    end
                                    else
                                    begin
                                        len_next = len_reg + CNT_W'(1);
                                    end
                                end
                            end
                            if (ch == CH_COMMA || ch == CH_STAR)
                            begin
                                star_next = (ch == CH_STAR);
                                fnum_next = fnum_reg + 3'd1;
                                case (fnum_reg)
                                    3'd0, 3'd1, 3'd2, 3'd3:
                                    begin
                                        if (len_reg >= need_len)
                                        begin
                                            seq_next    = SQ_DEC;
                                            dfield_next = fnum_reg[1:0];
                                            pos_next    = '0;
                                            acc_next    = '0;
                                            endp_next   = (fnum_reg == 3'd0) ? len_reg
                                                                             : need_len;
                                            if (fnum_reg == 3'd0)
                                            begin
                                                fraction_next = '0;
                                            end
                                        end
                                        else
                                        begin
                                            do_fail   = 1'b1;
                                            zero_time = 1'b1;
                                        end
                                    end
                                    3'd4, 3'd5:
                                    begin
                                        clr_word   = 1'b1;
                                        phase_next = (ch == CH_STAR) ? PH_CHECK : PH_FIELD;
                                    end
                                    default:
                                    begin
                                        do_fail   = 1'b1;
                                        zero_time = 1'b1;
                                    end
                                endcase
                            end
                        end
                        PH_CHECK:
                        begin
                            if (cnt_reg < CNT_W'(CHECK_CHARS) && !is_delim)
                            begin
                                chk_we   = 1'b1;
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                            if (ch == CH_CR || ch == CH_LF)
                            begin
                                if (chk_val == xor_reg)
                                begin
                                    clr_word   = 1'b1;
                                    ok_next    = 1'b1;
                                    phase_next = PH_DONE;
                                end
                                else
                                begin
                                    do_fail = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            do_fail = 1'b1;
                        end
                    endcase
                end
            end
            SQ_DEC:
            begin
                if ((dot_pos && fc != CH_DOT) || (!dot_pos && !fc_digit))
                begin
                    do_fail   = 1'b1;
                    zero_time = 1'b1;
                    seq_next  = SQ_PUB;
                end
                else
                begin
                    acc_next = dot_pos ? '0 : acc_sat;
                    // segment ends write the decoded value
                    case (dfield_reg)
                        2'd0:
                        begin
                            if (pos_reg == IDX_W'(1))
                            begin
                                hour_next = acc_sat[6:0];
                                acc_next  = '0;
                            end
                            else if (pos_reg == IDX_W'(3))
                            begin
                                minute_next = acc_sat[6:0];
                                acc_next    = '0;
                            end
                            else if (pos_reg == IDX_W'(5))
                            begin
                                second_next = acc_sat[6:0];
                                acc_next    = '0;
                            end
                            else if (pos_reg > IDX_W'(6) && last_pos)
                            begin
                                fraction_next = acc_sat;
                            end
                        end
                        2'd1:
                        begin
                            if (pos_reg == IDX_W'(1))
                            begin
                                day_next = acc_sat[6:0];
                            end
                        end
                        2'd2:
                        begin
                            if (pos_reg == IDX_W'(1))
                            begin
                                month_next = acc_sat[6:0];
                            end
                        end
                        default:
                        begin
                            if (pos_reg == IDX_W'(3))
                            begin
                                year_next = acc_sat[13:0];
                            end
                        end
                    endcase
                    if (last_pos)
                    begin
                        clr_word   = 1'b1;
                        phase_next = star_reg ? PH_CHECK : PH_FIELD;
                        seq_next   = SQ_PUB;
                    end
                    else
                    begin
                        pos_next = pos_reg + IDX_W'(1);
                    end
                end
            end
            SQ_PUB:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    seq_next       = SQ_WAIT;
                end
            end
            default:
            begin
                seq_next = SQ_WAIT;
            end
        endcase

        // word and sentence clearing
        if (clr_word || do_fail)
        begin
            cnt_next   = '0;
            len_next   = '0;
            zseen_next = 1'b0;
        end
        if (do_fail)
        begin
            xor_next   = '0;
            fnum_next  = '0;
            ok_next    = 1'b0;
            phase_next = PH_IDLE;
        end
        if (zero_time)
        begin
            hour_next     = '0;
            minute_next   = '0;
            second_next   = '0;
            fraction_next = '0;
            day_next      = '0;
            month_next    = '0;
            year_next     = '0;
        end
    end

    // control and time registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= SQ_WAIT;
            phase_reg     <= PH_IDLE;
            cnt_reg       <= '0;
            len_reg       <= '0;
            zseen_reg     <= 1'b0;
            xor_reg       <= '0;
            fnum_reg      <= '0;
            ok_reg        <= 1'b0;
            star_reg      <= 1'b0;
            dfield_reg    <= '0;
            pos_reg       <= '0;
            endp_reg      <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            hour_reg      <= '0;
            minute_reg    <= '0;
            second_reg    <= '0;
            fraction_reg  <= '0;
            day_reg       <= '0;
            month_reg     <= '0;
            year_reg      <= '0;
        end
        else
        begin
            seq_reg       <= seq_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            zseen_reg     <= zseen_next;
            xor_reg       <= xor_next;
            fnum_reg      <= fnum_next;
            ok_reg        <= ok_next;
            star_reg      <= star_next;
            dfield_reg    <= dfield_next;
            pos_reg       <= pos_next;
            endp_reg      <= endp_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            hour_reg      <= hour_next;
            minute_reg    <= minute_next;
            second_reg    <= second_next;
            fraction_reg  <= fraction_next;
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
        end
    end

    // word stores, written at the current character count
    always_ff @(posedge clk)
    begin
        if (talk_we)
        begin
            talker_reg[cnt_reg[0]] <= ch;
        end
        if (msg_we)
        begin
            msg_reg[cnt_reg[MIDX_W-1:0]] <= ch;
        end
        if (fld_we)
        begin
            field_reg[cnt_reg[IDX_W-1:0]] <= ch;
        end
        if (chk_we)
        begin
            chk_reg[cnt_reg[0]] <= ch;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            done_out_reg     <= ok_reg;
            hour_out_reg     <= hour_reg;
            minute_out_reg   <= minute_reg;
            second_out_reg   <= second_reg;
            fraction_out_reg <= fraction_reg;
            day_out_reg      <= day_reg;
            month_out_reg    <= month_reg;
            year_out_reg     <= year_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sentence_done = done_out_reg;
    assign hour          = hour_out_reg;
    assign minute        = minute_out_reg;
    assign second        = second_out_reg;
    assign fraction      = fraction_out_reg;
    assign day           = day_out_reg;
    assign month         = month_out_reg;
    assign year          = year_out_reg;

endmodule

// File: hdl/nzda_checker.sv
// ---------------------------------------------------------------------------
// nzda_checker
// Port-level checks for the ZDA sentence parser, bound to the parser module.
// ---------------------------------------------------------------------------
module nzda_checker
    import nzda_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        sentence_done,
    input logic [6:0]  hour,
    input logic [6:0]  minute,
    input logic [6:0]  second,
    input logic [29:0] fraction,
    input logic [6:0]  day,
    input logic [6:0]  month,
    input logic [13:0] year
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // one item in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

    // two-digit fields come only from checked decimal digits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hour <= 7'd99 && minute <= 7'd99 && second <= 7'd99 &&
                      day <= 7'd99 && month <= 7'd99)
        else $error("two-digit field out of range");

    // fraction saturates and year has four digits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fraction <= FRAC_MAX && year <= 14'd9999)
        else $error("fraction or year out of range");

endmodule

bind nmea_zda_sentence_parser nzda_checker u_nzda_checker (.*);

// File: sim/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the ZDA sentence parser: drives character items
// with random bursts and gaps, predicts every result item from a behavioral
// model of the parse, and compares each returned item field by field.
// ---------------------------------------------------------------------------
module tb;
    import nzda_pkg::*;

    localparam int MSG_N   = 3;
    localparam int FIELD_N = 16;
    localparam int LIMIT   = 400000;

    typedef struct packed {
        logic        done;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [29:0] fraction;
        logic [6:0]  day;
        logic [6:0]  month;
        logic [13:0] year;
    } zda_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  ch;
    logic        out_valid;
    logic        out_ready;
    logic        sentence_done;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [29:0] fraction;
    logic [6:0]  day;
    logic [6:0]  month;
    logic [13:0] year;

    nmea_zda_sentence_parser #(.MSG_CHARS(MSG_N), .FIELD_CHARS(FIELD_N)) uut (.*);

    // predictor state
    logic [2:0]  phase;
    int          cnt;
    logic [7:0]  talker [ID_CHARS];
    logic [7:0]  msg [MSG_N];
    logic [7:0]  fld [FIELD_N];
    logic [7:0]  chk [CHECK_CHARS];
    logic [7:0]  xsum;
    logic [2:0]  fnum;
    logic        ok_flag;
    zda_result_t tregs;

    logic [7:0]  char_queue[$];
    zda_result_t expected_results[$];
    int          mismatches;
    int          cycles;
    int          long_stall;

    function automatic bit is_delim(logic [7:0] c);
        return c == CH_COMMA || c == CH_STAR || c == CH_CR || c == CH_LF;
    endfunction

    function automatic void clear_word();
        foreach (fld[i]) fld[i] = '0;
        cnt = 0;
    endfunction

    function automatic void clear_sentence();
        clear_word();
        foreach (talker[i]) talker[i] = '0;
        foreach (msg[i]) msg[i] = '0;
        foreach (chk[i]) chk[i] = '0;
        xsum = '0;
        fnum = '0;
        ok_flag = 1'b0;
    endfunction

    function automatic int word_len();
        int i;
        for (i = 0; i < cnt && i < FIELD_N; i++)
            if (fld[i] == 8'h00) return i;
        return i;
    endfunction

    // decimal digits at pos, saturated like the fraction
    function automatic bit digits(int pos, int n, output logic [29:0] val);
        longint v;
        v = 0;
        val = '0;
        if (pos + n > word_len()) return 0;
        for (int i = pos; i < pos + n; i++)
        begin
            if (fld[i] < CH_ZERO || fld[i] > CH_NINE) return 0;
            v = v * 10 + (fld[i] - CH_ZERO);
            if (v > FRAC_MAX) v = FRAC_MAX;
        end
        val = v[29:0];
        return 1;
    endfunction

    function automatic bit decode_field();
        zda_result_t t;
        logic [29:0] a, b, c, f;
        bit ok;
        int len;
        t = tregs;
        ok = 1;
        case (fnum)
            3'd0:
            begin
                ok = digits(0, 2, a);
                if (ok) ok = digits(2, 2, b);
                if (ok) ok = digits(4, 2, c);
                if (ok)
                begin
                    t.hour = a[6:0]; t.minute = b[6:0]; t.second = c[6:0];
                end
                t.fraction = '0;
                len = word_len();
                if (ok && len >= 7)
                begin
                    if (fld[6] != CH_DOT) ok = 0;
                    else if (len >= 8)
                    begin
                        ok = digits(7, len - 7, f);
                        if (ok) t.fraction = f;
                    end
                end
            end
            3'd1: begin ok = digits(0, 2, a); t.day = a[6:0]; end
            3'd2: begin ok = digits(0, 2, a); t.month = a[6:0]; end
            3'd3: begin ok = digits(0, 4, a); t.year = a[13:0]; end
            3'd4, 3'd5: ok = 1;
            default: ok = 0;
        endcase
        if (ok) tregs = t;
        else tregs = '0;
        fnum = fnum + 3'd1;
        return ok;
    endfunction

    function automatic logic [7:0] check_value();
        logic [7:0] v;
        logic [4:0] d;
        v = '0;
        for (int i = 0; i < cnt && i < CHECK_CHARS; i++)
        begin
            d = 5'd0;
            if (chk[i] >= CH_ZERO && chk[i] <= CH_NINE) d = {1'b1, 4'(chk[i] - CH_ZERO)};
            else if (chk[i] >= 8'h61 && chk[i] <= 8'h66) d = {1'b1, 4'(chk[i] - 8'h57)};
            else if (chk[i] >= 8'h41 && chk[i] <= 8'h46) d = {1'b1, 4'(chk[i] - 8'h37)};
            if (!d[4]) break;
            v = {v[3:0], d[3:0]};
        end
        return v;
    endfunction

    function automatic void fail_sentence();
        clear_sentence();
        phase = PH_IDLE;
    endfunction

    // advance the parse by one character and queue the resulting item
    function automatic void parse_char(logic [7:0] c);
        zda_result_t r;
        case (phase)
            PH_IDLE:
                if (c == CH_DOLLAR)
                begin
                    clear_word();
                    phase = PH_TALKER;
                end
            PH_TALKER:
            begin
                if (c != CH_STAR) xsum ^= c;
                if (cnt < ID_CHARS && !is_delim(c)) begin talker[cnt] = c; cnt++; end
                if (cnt == ID_CHARS)
                begin
                    if (talker[0] == CH_G && talker[1] == CH_P)
                    begin
                        clear_word();
                        phase = PH_MESSAGE;
                    end
                    else fail_sentence();
                end
            end
            PH_MESSAGE:
            begin
                if (c != CH_STAR) xsum ^= c;
                if (cnt < MSG_N && !is_delim(c)) begin msg[cnt] = c; cnt++; end
                if (c == CH_COMMA)
                begin
                    if (cnt == 3 && msg[0] == CH_Z && msg[1] == CH_D && msg[2] == CH_A)
                    begin
                        clear_word();
                        phase = PH_FIELD;
                    end
                    else fail_sentence();
                end
            end
            PH_FIELD:
            begin
                if (c != CH_STAR) xsum ^= c;
                if (cnt < FIELD_N && !is_delim(c)) begin fld[cnt] = c; cnt++; end
                if (c == CH_COMMA || c == CH_STAR)
                begin
                    if (decode_field())
                    begin
                        clear_word();
                        phase = (c == CH_COMMA) ? PH_FIELD : PH_CHECK;
                    end
                    else fail_sentence();
                end
            end
            PH_CHECK:
            begin
                if (cnt < CHECK_CHARS && !is_delim(c)) begin chk[cnt] = c; cnt++; end
                if (c == CH_CR || c == CH_LF)
                begin
                    if (check_value() == xsum)
                    begin
                        clear_word();
                        ok_flag = 1'b1;
                        phase = PH_DONE;
                    end
                    else fail_sentence();
                end
            end
            default: fail_sentence();
        endcase
        r = tregs;
        r.done = ok_flag;
        expected_results.push_back(r);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) char_queue.push_back(s[i]);
    endfunction

    function automatic string digit_text(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
        return s;
    endfunction

    // sentence body with correct or broken checksum and chosen terminator
    function automatic void push_sentence(string body, bit good, bit lower, bit lf);
        logic [7:0] x;
        x = '0;
        for (int i = 0; i < body.len(); i++) x ^= body[i];
        if (!good) x ^= 8'(1 + $urandom_range(0, 254));
        push_text({"$", body, "*"});
        push_text(lower ? $sformatf("%02x", x) : $sformatf("%02X", x));
        char_queue.push_back(lf ? CH_LF : CH_CR);
        char_queue.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic string random_body();
        string t;
        int k;
        k = $urandom_range(0, 9);
        t = {digit_text(6)};
        if (k > 2) t = {t, ".", digit_text($urandom_range(0, 9))};
        t = {"GPZDA,", t, ",", digit_text(2), ",", digit_text(2), ",", digit_text(4)};
        if ($urandom_range(0, 3) != 0) t = {t, ",", digit_text(2), ",", digit_text(2)};
        if (k == 0) t = {t, ",", digit_text(2)};
        if (k == 1)
        begin
            int p;
            p = $urandom_range(0, t.len() - 1);
            t[p] = 8'($urandom_range(0, 255));
            if (t[p] == CH_STAR || t[p] == CH_CR || t[p] == CH_LF || t[p] == 8'h00)
                t[p] = CH_ZERO;
        end
        return t;
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // stimulus
    initial
    begin
        rst_n = 1'b0;
        clear_sentence();
        phase = PH_IDLE;
        tregs = '0;
        // directed: good sentences with both cases of checksum and both terminators, then malformed ones
        push_sentence("GPZDA,235959.123,31,12,9999,00,00", 1, 0, 0);
        push_sentence("GPZDA,000000,01,01,0000,,", 1, 1, 1);
        push_sentence("GPZDA,120000.99999999999,15,06,2024,-1,00", 1, 0, 1);
        push_sentence("GPZDA,12000x,15,06,2024", 1, 0, 0);
        push_sentence("GPZDA,120000,15,06,2024", 0, 0, 0);
        push_sentence("GNZDA,120000,15,06,2024", 1, 0, 0);
        push_sentence("GPZDAX,120000,15,06,2024", 1, 0, 0);
        push_sentence("GPZDA,1,2,3,4,5,6,7", 1, 0, 0);
        push_sentence("GPZDA,123456X,01,02,2003", 1, 0, 0);
        push_text("$G,P*ZDA,$,*\r\n");
        push_text({"$GPZDA,", string'(8'h00), "1,*\n"});
        push_text("$GPZDA,010203,04,05,0006*z\r$GPZDA,,*\n");
        char_queue.push_back(8'hFF);
        char_queue.push_back(8'h00);
        // random: mostly sentences, some noise
        while (char_queue.size() < 1200)
        begin
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 8)) char_queue.push_back(8'($urandom_range(0, 255)));
            else
                push_sentence(random_body(), $urandom_range(0, 4) != 0,
                              $urandom_range(0, 1), $urandom_range(0, 1));
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // acceptance of the input item, noted at the rising edge
    logic in_ready_seen;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) in_ready_seen <= 1'b0;
        else
        begin
            in_ready_seen <= in_valid && in_ready;
            if (in_valid && in_ready) parse_char(ch);
        end
    end

    // driver: bursts with gaps and one pause until drained
    int burst_left;
    int gap_left;
    int sent;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            ch <= '0;
            burst_left <= 0;
            gap_left <= 0;
            sent <= 0;
        end
        else if (!in_valid || in_ready_seen)
        begin
            if (sent == 600 && expected_results.size() != 0)
                in_valid <= 1'b0;
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (char_queue.size() != 0)
            begin
                in_valid <= 1'b1;
                ch <= char_queue.pop_front();
                sent <= sent + 1;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
                else burst_left <= burst_left - 1;
            end
            else in_valid <= 1'b0;
        end
    end

    // receiver stall pattern, with one long hold-off
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            long_stall <= 0;
        end
        else if (sent == 300 && long_stall == 0)
        begin
            out_ready <= 1'b0;
            long_stall <= 1;
        end
        else if (long_stall > 0 && long_stall < 200)
        begin
            out_ready <= 1'b0;
            long_stall <= long_stall + 1;
        end
        else
            out_ready <= (cycles % 64 < 32) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // monitor
    always @(posedge clk)
    begin
        zda_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0) report("unexpected item", 1, 0);
            else
            begin
                e = expected_results.pop_front();
                if (sentence_done !== e.done) report("sentence_done", sentence_done, e.done);
                if (hour !== e.hour) report("hour", hour, e.hour);
                if (minute !== e.minute) report("minute", minute, e.minute);
                if (second !== e.second) report("second", second, e.second);
                if (fraction !== e.fraction) report("fraction", fraction, e.fraction);
                if (day !== e.day) report("day", day, e.day);
                if (month !== e.month) report("month", month, e.month);
                if (year !== e.year) report("year", year, e.year);
            end
        end
    end

    // end of run and timeout
    initial
    begin
        mismatches = 0;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            if (rst_n && char_queue.size() == 0 && !in_valid && expected_results.size() == 0)
            begin
                repeat (40) @(posedge clk);
                if (mismatches == 0 && expected_results.size() == 0)
                    $display("No mismatches found");
                else
                    $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule
